// ===== sv/dcp_pkg.sv =====
// Shared types and constants for the display command parser.
// Holds the field position enum, the result beat struct, the ASCII codes and the field digit limit function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dcp_pkg;

   // Default text capacity in bytes
   localparam int MAX_TEXT_DEF = 64;

   // ASCII codes used by the parser
   localparam logic [7:0] CHAR_ZERO     = 8'd48;
   localparam logic [7:0] CHAR_COMMA    = 8'd44;
   localparam logic [7:0] CHAR_NEWLINE  = 8'd10;
   localparam logic [7:0] CHAR_MAX_MODE = 8'd50;   // '2'
   localparam logic [7:0] CHAR_MAX_DIG  = 8'd57;   // '9'
   localparam logic [7:0] CHAR_MAX_ROT  = 8'd49;   // '1'

   // Where the parser stands within a message
   typedef enum logic [2:0] {
      POS_MODE   = 3'd0,
      POS_BRIGHT = 3'd1,
      POS_SPEED  = 3'd2,
      POS_ROT    = 3'd3,
      POS_TEXT   = 3'd4,
      POS_AFTER  = 3'd5
   } pos_type;

   // One result beat
   typedef struct packed {
      logic       text_valid;
      logic [5:0] text_index;
      logic [7:0] text_char;
      logic       done_res;
      logic       ok;
      logic [1:0] display_mode;
      logic [3:0] brightness;
      logic [3:0] scroll_speed;
      logic       rotation;
      logic [6:0] text_count;
   } rsp_type;

   // Highest ASCII digit accepted in a setting field
   function automatic logic [7:0] field_char_max(input pos_type pos);
      logic [7:0] lim;
      unique case (pos)
         POS_MODE: lim = CHAR_MAX_MODE;
         POS_ROT:  lim = CHAR_MAX_ROT;
         default:  lim = CHAR_MAX_DIG;
      endcase
      return lim;
   endfunction

endpackage

`default_nettype wire

// ===== sv/display_command_parser.sv =====
// Display command parser: one result beat per message byte, one byte per cycle while req_stall is low.
// Each result is registered in the output buffer, in the skid entry if the output register still holds a beat.
// The per-byte state update is combinational, so bytes are taken back to back while the buffer has room.
// A two-entry output buffer keeps taking bytes while one result waits.
// Reset (synchronous) returns the parser to the first field and empties the buffer.
`timescale 1ns / 1ps
`default_nettype none

module display_command_parser #(
   parameter int MAX_TEXT = dcp_pkg::MAX_TEXT_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_last_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_text_valid,
   output logic [5:0]      rsp_text_index,
   output logic [7:0]      rsp_text_char,
   output logic            rsp_done_res,
   output logic            rsp_ok,
   output logic [1:0]      rsp_display_mode,
   output logic [3:0]      rsp_brightness,
   output logic [3:0]      rsp_scroll_speed,
   output logic            rsp_rotation,
   output logic [6:0]      rsp_text_count
);

   logic             accept;
   dcp_pkg::rsp_type new_rsp;
   dcp_pkg::rsp_type out_rsp;

   assign accept = req_valid && !req_stall;

   // Decode the byte against the running message state
   dcp_parser #(
      .MAX_TEXT (MAX_TEXT)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .result    (new_rsp)
   );

   // Hold result beats until the receiver takes them
   dcp_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (new_rsp),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_rsp)
   );

   assign rsp_text_valid   = out_rsp.text_valid;
   assign rsp_text_index   = out_rsp.text_index;
   assign rsp_text_char    = out_rsp.text_char;
   assign rsp_done_res     = out_rsp.done_res;
   assign rsp_ok           = out_rsp.ok;
   assign rsp_display_mode = out_rsp.display_mode;
   assign rsp_brightness   = out_rsp.brightness;
   assign rsp_scroll_speed = out_rsp.scroll_speed;
   assign rsp_rotation     = out_rsp.rotation;
   assign rsp_text_count   = out_rsp.text_count;

endmodule

`default_nettype wire

// ===== sv/dcp_parser.sv =====
// Per-byte parser state and result computation for the display command parser.
// Depends on dcp_pkg for the position enum, ASCII codes and result struct.
`timescale 1ns / 1ps
`default_nettype none

module dcp_parser #(
   parameter int MAX_TEXT = dcp_pkg::MAX_TEXT_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic [7:0]       data_byte,
   input  wire logic             last_byte,
   output dcp_pkg::rsp_type      result
);

   localparam int CNT_RAW = $clog2(MAX_TEXT + 1);
   localparam int CNT_W   = (CNT_RAW > 7) ? CNT_RAW : 7;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TEXT);

   dcp_pkg::pos_type pos_ff, pos_in;
   logic [1:0]       fchars_ff, fchars_in;
   logic [1:0]       mode_ff, mode_in;
   logic [3:0]       bright_ff, bright_in;
   logic [3:0]       speed_ff, speed_in;
   logic             rot_ff, rot_in;
   logic             err_ff, err_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic digit_ok;
   logic text_store;

   assign digit_ok   = (data_byte >= dcp_pkg::CHAR_ZERO) &&
                       (data_byte <= dcp_pkg::field_char_max(pos_ff));
   assign text_store = (pos_ff == dcp_pkg::POS_TEXT) &&
                       (data_byte != dcp_pkg::CHAR_NEWLINE) && (cnt_ff < CNT_MAX);

   // Next state for one byte
   always_comb begin
      pos_in    = pos_ff;
      fchars_in = fchars_ff;
      mode_in   = mode_ff;
      bright_in = bright_ff;
      speed_in  = speed_ff;
      rot_in    = rot_ff;
      err_in    = err_ff;
      cnt_in    = cnt_ff;
      unique case (pos_ff)
         dcp_pkg::POS_MODE, dcp_pkg::POS_BRIGHT, dcp_pkg::POS_SPEED,
         dcp_pkg::POS_ROT: begin
            if (data_byte == dcp_pkg::CHAR_COMMA) begin
               // close the field: exactly one byte is allowed
               if (fchars_ff != 2'd1) err_in = 1'b1;
               pos_in    = dcp_pkg::pos_type'(3'(pos_ff) + 3'd1);
               fchars_in = 2'd0;
            end else begin
               if (fchars_ff == 2'd0 && digit_ok) begin
                  unique case (pos_ff)
                     dcp_pkg::POS_MODE:   mode_in   = data_byte[1:0];
                     dcp_pkg::POS_BRIGHT: bright_in = data_byte[3:0];
                     dcp_pkg::POS_SPEED:  speed_in  = data_byte[3:0];
                     default:             rot_in    = data_byte[0];
                  endcase
               end else begin
                  err_in = 1'b1;
               end
               if (fchars_ff < 2'd2) fchars_in = fchars_ff + 2'd1;
            end
         end
         dcp_pkg::POS_TEXT: begin
            if (data_byte == dcp_pkg::CHAR_NEWLINE) begin
               pos_in = dcp_pkg::POS_AFTER;
            end else if (cnt_ff < CNT_MAX) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end else begin
               // overflow byte: drop it and flag the message
               err_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Result beat for this byte
   always_comb begin
      result              = '0;
      result.text_valid   = text_store;
      result.text_index   = text_store ? cnt_ff[5:0] : 6'd0;
      result.text_char    = text_store ? data_byte : 8'd0;
      if (last_byte) begin
         result.done_res     = 1'b1;
         result.ok           = !err_in &&
                               ((pos_in == dcp_pkg::POS_TEXT) ||
                                (pos_in == dcp_pkg::POS_AFTER));
         result.display_mode = mode_in;
         result.brightness   = bright_in;
         result.scroll_speed = speed_in;
         result.rotation     = rot_in;
         result.text_count   = cnt_in[6:0];
      end
   end

   // Advance on each accepted beat; clear on reset and after the last byte of a message
   always_ff @(posedge clock) begin
      if (reset || (accept && last_byte)) begin
         pos_ff    <= dcp_pkg::POS_MODE;
         fchars_ff <= 2'd0;
         mode_ff   <= 2'd0;
         bright_ff <= 4'd0;
         speed_ff  <= 4'd0;
         rot_ff    <= 1'b0;
         err_ff    <= 1'b0;
         cnt_ff    <= '0;
      end else if (accept) begin
         pos_ff    <= pos_in;
         fchars_ff <= fchars_in;
         mode_ff   <= mode_in;
         bright_ff <= bright_in;
         speed_ff  <= speed_in;
         rot_ff    <= rot_in;
         err_ff    <= err_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/dcp_skid.sv =====
// Output register with a skid stage for result beats of the parser.
// Depends on dcp_pkg for the result struct.
`timescale 1ns / 1ps
`default_nettype none

module dcp_skid (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_stall,
   input  wire dcp_pkg::rsp_type in_data,
   output logic              out_valid,
   input  wire logic         out_stall,
   output dcp_pkg::rsp_type  out_data
);

   logic             main_valid_ff;
   logic             skid_valid_ff;
   dcp_pkg::rsp_type main_ff;
   dcp_pkg::rsp_type skid_ff;
   logic             take;
   logic             push;

   assign in_stall  = skid_valid_ff;
   assign push      = in_valid && !skid_valid_ff;
   assign take      = main_valid_ff && !out_stall;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (take || !main_valid_ff) begin
            main_valid_ff <= skid_valid_ff || push;
            skid_valid_ff <= 1'b0;
         end else if (push) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   // Payload: refill the output from the skid first, else from the new beat
   always_ff @(posedge clock) begin
      if (take || !main_valid_ff) begin
         main_ff <= skid_valid_ff ? skid_ff : in_data;
      end else if (push) begin
         skid_ff <= in_data;
      end
   end

endmodule

`default_nettype wire
